// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the block; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is high
`define DBDC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well
`define DBDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DBDC_ASSERT(label, clk, rst, prop, msg)
`define DBDC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/dbdc_pkg.sv =====
// ----------------------------------------------------------------------------
// dbdc_pkg
// Types and constants of the dual beam direction counter.
// ----------------------------------------------------------------------------
package dbdc_pkg;

  localparam int DIST_W     = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0] INVALID_DIST = 14'd15984;
  localparam logic [15:0]       MAX_WIDTH    = 16'd25000;
  localparam logic [10:0]       DIST_SCALE   = 11'd1124;
  localparam logic [14:0]       MIN_DIST     = 15'd32;
  localparam logic [14:0]       MAX_DIST     = 15'd6400;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 3'd4;

  typedef struct packed {
    logic [15:0] echo_width_a;
    logic [15:0] echo_width_b;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]        crossing_event;
    logic [15:0]       occupancy_now;
    logic [31:0]       in_total;
    logic [31:0]       out_total;
    logic [DIST_W-1:0] filtered_a;
    logic [DIST_W-1:0] filtered_b;
    logic [2:0]        gate_state;
  } out_t;

  typedef struct packed {
    logic [DIST_W-1:0] enter_threshold;
    logic [DIST_W-1:0] leave_threshold;
    logic [15:0]       crossing_limit;
    logic [15:0]       rearm_gap;
    logic              swap_beams;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;
    logic [31:0]       time_ms;
  } q_item_t;

endpackage

// ===== rtl/dbdc_front.sv =====
// ----------------------------------------------------------------------------
// dbdc_front
// Accepts requests and turns each echo width into a distance in 1/16 cm.
// ----------------------------------------------------------------------------
module dbdc_front (
  input  dbdc_pkg::in_t     in_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              q_full,
  output logic              push,
  output dbdc_pkg::q_item_t push_data
);
  import dbdc_pkg::*;

  function automatic logic [DIST_W-1:0] width_to_dist(input logic [15:0] w);
    logic [26:0] prod;
    logic [14:0] d;
    prod = 27'(w) * 27'(DIST_SCALE);
    d    = prod[26:12];
    if (w == 16'd0 || w >= MAX_WIDTH || d < MIN_DIST || d > MAX_DIST) begin
      return INVALID_DIST;
    end
    return d[DIST_W-1:0];
  endfunction

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data.dist_a  = width_to_dist(in_data.echo_width_a);
    push_data.dist_b  = width_to_dist(in_data.echo_width_b);
    push_data.time_ms = in_data.time_ms;
  end

endmodule

// ===== rtl/dbdc_queue.sv =====
// ----------------------------------------------------------------------------
// dbdc_queue
// Short first-word-fall-through queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbdc_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dbdc_pkg::q_item_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output dbdc_pkg::q_item_t pop_data
);
  import dbdc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `DBDC_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `DBDC_ASSERT(a_pop_nonempty, clk, rst, pop |-> pop_valid, "pop from empty queue")
  `DBDC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> count == '0, "queue not empty after reset")

endmodule

// ===== rtl/dbdc_back.sv =====
// ----------------------------------------------------------------------------
// dbdc_back
// Median filter, blocked latch, direction state machine and counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbdc_back (
  input  logic              clk,
  input  logic              rst,
  input  dbdc_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  dbdc_pkg::q_item_t q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output dbdc_pkg::out_t    out_data
);
  import dbdc_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_IN_A     = 3'd1;
  localparam logic [2:0] PH_IN_BOTH  = 3'd2;
  localparam logic [2:0] PH_IN_B     = 3'd3;
  localparam logic [2:0] PH_OUT_B    = 3'd4;
  localparam logic [2:0] PH_OUT_BOTH = 3'd5;
  localparam logic [2:0] PH_OUT_A    = 3'd6;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_IN   = 2'd1;
  localparam logic [1:0] EV_OUT  = 2'd2;

  localparam logic [1:0] SLOT_LAST = 2'd2;

  function automatic logic [DIST_W-1:0] mid3(input logic [DIST_W-1:0] x,
                                             input logic [DIST_W-1:0] y,
                                             input logic [DIST_W-1:0] z);
    if ((x <= y && y <= z) || (z <= y && y <= x)) begin
      return y;
    end
    if ((y <= x && x <= z) || (z <= x && x <= y)) begin
      return x;
    end
    return z;
  endfunction

  logic [DIST_W-1:0] history_a [3];
  logic [DIST_W-1:0] history_b [3];
  logic [DIST_W-1:0] hist_a_next [3];
  logic [DIST_W-1:0] hist_b_next [3];
  logic [1:0]        ring_slot;
  logic              blocked_a;
  logic              blocked_b;
  logic [2:0]        fsm_phase;
  logic [31:0]       phase_start_ms;
  logic [31:0]       last_count_ms;
  logic [15:0]       occupancy_reg;
  logic [31:0]       in_count;
  logic [31:0]       out_count;

  logic [DIST_W-1:0] da;
  logic [DIST_W-1:0] db;
  logic              blocked_a_next;
  logic              blocked_b_next;
  logic              x;
  logic              y;
  logic              timed_out;
  logic              cooling;
  logic [2:0]        phase_next;
  logic              start_phase;
  logic              count_in;
  logic              count_out;
  logic [1:0]        event_code;
  logic [15:0]       occupancy_next;
  logic [31:0]       in_count_next;
  logic [31:0]       out_count_next;
  logic [31:0]       now;

  assign pop = q_valid && (!out_valid || !out_stall);
  assign now = q_data.time_ms;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hist_a_next[i] = (ring_slot == 2'(i)) ? q_data.dist_a : history_a[i];
      hist_b_next[i] = (ring_slot == 2'(i)) ? q_data.dist_b : history_b[i];
    end
  end

  assign da = mid3(hist_a_next[0], hist_a_next[1], hist_a_next[2]);
  assign db = mid3(hist_b_next[0], hist_b_next[1], hist_b_next[2]);

  assign blocked_a_next = blocked_a ? (da < cfg.leave_threshold) : (da < cfg.enter_threshold);
  assign blocked_b_next = blocked_b ? (db < cfg.leave_threshold) : (db < cfg.enter_threshold);

  assign x = cfg.swap_beams ? blocked_b_next : blocked_a_next;
  assign y = cfg.swap_beams ? blocked_a_next : blocked_b_next;

  assign timed_out = (now - phase_start_ms) > {16'd0, cfg.crossing_limit};
  assign cooling   = (now - last_count_ms) < {16'd0, cfg.rearm_gap};

  always_comb begin
    phase_next  = fsm_phase;
    start_phase = 1'b0;
    count_in    = 1'b0;
    count_out   = 1'b0;
    case (fsm_phase)
      PH_IN_A: begin
        if (x && y) phase_next = PH_IN_BOTH;
        else if (!x && !y) phase_next = PH_IDLE;
        else if (timed_out) phase_next = PH_IDLE;
      end
      PH_IN_BOTH: begin
        if (!x && y) phase_next = PH_IN_B;
        else if (x && !y) phase_next = PH_IN_A;
        else if (!x && !y) count_in = 1'b1;
        else if (timed_out) phase_next = PH_IDLE;
      end
      PH_IN_B: begin
        if (!x && !y) count_in = 1'b1;
        else if (x && y) phase_next = PH_IN_BOTH;
        else if (timed_out) phase_next = PH_IDLE;
      end
      PH_OUT_B: begin
        if (x && y) phase_next = PH_OUT_BOTH;
        else if (!x && !y) phase_next = PH_IDLE;
        else if (timed_out) phase_next = PH_IDLE;
      end
      PH_OUT_BOTH: begin
        if (x && !y) phase_next = PH_OUT_A;
        else if (!x && y) phase_next = PH_OUT_B;
        else if (!x && !y) count_out = 1'b1;
        else if (timed_out) phase_next = PH_IDLE;
      end
      PH_OUT_A: begin
        if (!x && !y) count_out = 1'b1;
        else if (x && y) phase_next = PH_OUT_BOTH;
        else if (timed_out) phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        if (!cooling && x && !y) begin
          phase_next  = PH_IN_A;
          start_phase = 1'b1;
        end else if (!cooling && y && !x) begin
          phase_next  = PH_OUT_B;
          start_phase = 1'b1;
        end
      end
    endcase
    if (count_in || count_out) begin
      phase_next = PH_IDLE;
    end
  end

  always_comb begin
    occupancy_next = occupancy_reg;
    in_count_next  = in_count;
    out_count_next = out_count;
    event_code     = EV_NONE;
    if (count_in) begin
      in_count_next = in_count + 32'd1;
      event_code    = EV_IN;
      if (occupancy_reg != 16'hFFFF) occupancy_next = occupancy_reg + 16'd1;
    end else if (count_out) begin
      out_count_next = out_count + 32'd1;
      event_code     = EV_OUT;
      if (occupancy_reg != 16'd0) occupancy_next = occupancy_reg - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        history_a[i] <= INVALID_DIST;
        history_b[i] <= INVALID_DIST;
      end
      ring_slot      <= 2'd0;
      blocked_a      <= 1'b0;
      blocked_b      <= 1'b0;
      fsm_phase      <= PH_IDLE;
      phase_start_ms <= 32'd0;
      last_count_ms  <= 32'd0;
      occupancy_reg  <= 16'd0;
      in_count       <= 32'd0;
      out_count      <= 32'd0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        for (int i = 0; i < 3; i++) begin
          history_a[i] <= hist_a_next[i];
          history_b[i] <= hist_b_next[i];
        end
        ring_slot     <= (ring_slot >= SLOT_LAST) ? 2'd0 : ring_slot + 2'd1;
        blocked_a     <= blocked_a_next;
        blocked_b     <= blocked_b_next;
        fsm_phase     <= phase_next;
        occupancy_reg <= occupancy_next;
        in_count      <= in_count_next;
        out_count     <= out_count_next;
        if (start_phase) phase_start_ms <= now;
        if (count_in || count_out) last_count_ms <= now;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.crossing_event <= event_code;
      out_data.occupancy_now  <= occupancy_next;
      out_data.in_total       <= in_count_next;
      out_data.out_total      <= out_count_next;
      out_data.filtered_a     <= da;
      out_data.filtered_b     <= db;
      out_data.gate_state     <= phase_next;
    end
  end

  `DBDC_ASSERT(a_idle_after_count, clk, rst,
               pop && (count_in || count_out) |=> fsm_phase == PH_IDLE,
               "phase not idle after a count")
  `DBDC_ASSERT(a_out_count_step, clk, rst,
               pop && count_out |=> out_count == $past(out_count) + 32'd1,
               "out total did not advance")
  `DBDC_ASSERT(a_hold_when_idle, clk, rst,
               !pop |=> $stable(occupancy_reg) && $stable(fsm_phase),
               "state moved without a request")

endmodule

// ===== rtl/dual_beam_direction_counter.sv =====
// ----------------------------------------------------------------------------
// dual_beam_direction_counter
// Two-beam doorway counter: distance conversion, median filter, hysteresis
// latch and a direction state machine that counts in and out crossings.
// ----------------------------------------------------------------------------
// The block takes one sample request per clock cycle, sustained, while the
// output is not stalled, and returns one result for every sample. A sample is
// converted as it is accepted and queued; the back end pops it once its output
// register is free and updates filter, latch, state machine and counters as
// it pops, registering the result with out_valid. The input stalls only while the
// queue of QUEUE_DEPTH entries is full, which happens only when the output is
// stalled. Write the configuration registers only while no sample is in flight.
// ----------------------------------------------------------------------------
module dual_beam_direction_counter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dbdc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dbdc_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [dbdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dbdc_pkg::*;

  cfg_t    cfg;
  logic    push;
  q_item_t push_data;
  logic    q_full;
  logic    pop;
  logic    q_valid;
  q_item_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_threshold <= 14'd1280;
      cfg.leave_threshold <= 14'd1600;
      cfg.crossing_limit  <= 16'd3000;
      cfg.rearm_gap       <= 16'd500;
      cfg.swap_beams      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTER:    cfg.enter_threshold <= cfg_data[DIST_W-1:0];
        CFG_LEAVE:    cfg.leave_threshold <= cfg_data[DIST_W-1:0];
        CFG_TIMEOUT:  cfg.crossing_limit  <= cfg_data;
        CFG_COOLDOWN: cfg.rearm_gap       <= cfg_data;
        CFG_INVERT:   cfg.swap_beams      <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  dbdc_front u_front (
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  dbdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  dbdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/dual_beam_direction_counter_checker.sv =====
// ----------------------------------------------------------------------------
// dual_beam_direction_counter_checker
// Watches the sample and result channels and the register port of the
// doorway counter. Keeps its own copy of the filter, latch, direction state
// machine and totals, predicts the result of every accepted sample request
// and compares each accepted result field by field, oldest first.
// ----------------------------------------------------------------------------
module dual_beam_direction_counter_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  dbdc_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  dbdc_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [dbdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fault_count,
  output int                              outstanding
);
  import dbdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    GATE_IDLE     = 3'd0,
    GATE_IN_A     = 3'd1,
    GATE_IN_BOTH  = 3'd2,
    GATE_IN_B     = 3'd3,
    GATE_OUT_B    = 3'd4,
    GATE_OUT_BOTH = 3'd5,
    GATE_OUT_A    = 3'd6
  } gate_e;

  typedef enum logic [1:0] {
    CROSS_NONE = 2'd0,
    CROSS_IN   = 2'd1,
    CROSS_OUT  = 2'd2
  } cross_e;

  cfg_t              settings;
  logic [DIST_W-1:0] hist_a [3];
  logic [DIST_W-1:0] hist_b [3];
  logic [1:0]        slot;
  logic              blk_a;
  logic              blk_b;
  gate_e             gate;
  logic [31:0]       phase_start;
  logic [31:0]       last_count;
  logic [15:0]       occupancy;
  logic [31:0]       in_count;
  logic [31:0]       out_count;

  out_t              expected_q [$];
  out_t              want;
  int                results_seen;

  function automatic logic [DIST_W-1:0] echo_to_dist(input logic [15:0] w);
    logic [31:0] prod;
    prod = (32'(w) * 32'(DIST_SCALE)) >> 12;
    if (w == 16'd0 || w >= MAX_WIDTH) return INVALID_DIST;
    if (prod < 32'(MIN_DIST) || prod > 32'(MAX_DIST)) return INVALID_DIST;
    return prod[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] median3(input logic [DIST_W-1:0] a, b, c);
    if (a <= b) return (b <= c) ? b : ((a <= c) ? c : a);
    return (a <= c) ? a : ((b <= c) ? c : b);
  endfunction

  function automatic out_t predict_sample(input in_t s);
    out_t              r;
    logic [DIST_W-1:0] da;
    logic [DIST_W-1:0] db;
    logic              x;
    logic              y;
    logic              timed_out;
    logic              add_in;
    logic              add_out;
    logic [31:0]       elapsed;
    logic [31:0]       since_count;
    add_in  = 1'b0;
    add_out = 1'b0;
    if (slot < 2'd3) begin
      hist_a[slot] = echo_to_dist(s.echo_width_a);
      hist_b[slot] = echo_to_dist(s.echo_width_b);
    end
    slot = (slot >= 2'd2) ? 2'd0 : slot + 2'd1;
    da = median3(hist_a[0], hist_a[1], hist_a[2]);
    db = median3(hist_b[0], hist_b[1], hist_b[2]);
    blk_a = blk_a ? (da < settings.leave_threshold) : (da < settings.enter_threshold);
    blk_b = blk_b ? (db < settings.leave_threshold) : (db < settings.enter_threshold);
    x = settings.swap_beams ? blk_b : blk_a;
    y = settings.swap_beams ? blk_a : blk_b;
    elapsed     = s.time_ms - phase_start;
    since_count = s.time_ms - last_count;
    timed_out   = elapsed > 32'(settings.crossing_limit);
    case (gate)
      GATE_IN_A: begin
        if (x && y) gate = GATE_IN_BOTH;
        else if (!x && !y) gate = GATE_IDLE;
        else if (timed_out) gate = GATE_IDLE;
      end
      GATE_IN_BOTH: begin
        if (!x && y) gate = GATE_IN_B;
        else if (x && !y) gate = GATE_IN_A;
        else if (!x && !y) add_in = 1'b1;
        else if (timed_out) gate = GATE_IDLE;
      end
      GATE_IN_B: begin
        if (!x && !y) add_in = 1'b1;
        else if (x && y) gate = GATE_IN_BOTH;
        else if (timed_out) gate = GATE_IDLE;
      end
      GATE_OUT_B: begin
        if (x && y) gate = GATE_OUT_BOTH;
        else if (!x && !y) gate = GATE_IDLE;
        else if (timed_out) gate = GATE_IDLE;
      end
      GATE_OUT_BOTH: begin
        if (x && !y) gate = GATE_OUT_A;
        else if (!x && y) gate = GATE_OUT_B;
        else if (!x && !y) add_out = 1'b1;
        else if (timed_out) gate = GATE_IDLE;
      end
      GATE_OUT_A: begin
        if (!x && !y) add_out = 1'b1;
        else if (x && y) gate = GATE_OUT_BOTH;
        else if (timed_out) gate = GATE_IDLE;
      end
      default: begin
        gate = GATE_IDLE;
        if (since_count >= 32'(settings.rearm_gap)) begin
          if (x && !y) begin
            gate        = GATE_IN_A;
            phase_start = s.time_ms;
          end else if (y && !x) begin
            gate        = GATE_OUT_B;
            phase_start = s.time_ms;
          end
        end
      end
    endcase
    r.crossing_event = CROSS_NONE;
    if (add_in) begin
      in_count++;
      if (occupancy != 16'hFFFF) occupancy++;
      last_count       = s.time_ms;
      gate             = GATE_IDLE;
      r.crossing_event = CROSS_IN;
    end else if (add_out) begin
      out_count++;
      if (occupancy != 16'd0) occupancy--;
      last_count       = s.time_ms;
      gate             = GATE_IDLE;
      r.crossing_event = CROSS_OUT;
    end
    r.occupancy_now = occupancy;
    r.in_total      = in_count;
    r.out_total     = out_count;
    r.filtered_a    = da;
    r.filtered_b    = db;
    r.gate_state    = gate;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got, wanted);
    fault_count++;
    $display("%0t result %0d: %s is %0d, predicted %0d", $time, results_seen, what, got,
             wanted);
  endtask

  task automatic check_field(input string what, input logic [31:0] got, wanted);
    if (got !== wanted) flag_mismatch(what, got, wanted);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settings.enter_threshold = 14'd1280;
      settings.leave_threshold = 14'd1600;
      settings.crossing_limit  = 16'd3000;
      settings.rearm_gap       = 16'd500;
      settings.swap_beams      = 1'b0;
      for (int i = 0; i < 3; i++) begin
        hist_a[i] = INVALID_DIST;
        hist_b[i] = INVALID_DIST;
      end
      slot         = 2'd0;
      blk_a        = 1'b0;
      blk_b        = 1'b0;
      gate         = GATE_IDLE;
      phase_start  = 32'd0;
      last_count   = 32'd0;
      occupancy    = 16'd0;
      in_count     = 32'd0;
      out_count    = 32'd0;
      fault_count  = 0;
      results_seen = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTER:    settings.enter_threshold = cfg_data[DIST_W-1:0];
          CFG_LEAVE:    settings.leave_threshold = cfg_data[DIST_W-1:0];
          CFG_TIMEOUT:  settings.crossing_limit  = cfg_data;
          CFG_COOLDOWN: settings.rearm_gap       = cfg_data;
          CFG_INVERT:   settings.swap_beams      = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_sample(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          flag_mismatch("result with no request outstanding", 32'd0, 32'd0);
        end else begin
          want = expected_q.pop_front();
          check_field("crossing_event", 32'(out_data.crossing_event),
                      32'(want.crossing_event));
          check_field("occupancy_now", 32'(out_data.occupancy_now),
                      32'(want.occupancy_now));
          check_field("in_total", out_data.in_total, want.in_total);
          check_field("out_total", out_data.out_total, want.out_total);
          check_field("filtered_a", 32'(out_data.filtered_a), 32'(want.filtered_a));
          check_field("filtered_b", 32'(out_data.filtered_b), 32'(want.filtered_b));
          check_field("gate_state", 32'(out_data.gate_state), 32'(want.gate_state));
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== tb/dual_beam_direction_counter_tb.sv =====
// ----------------------------------------------------------------------------
// dual_beam_direction_counter_tb
// Drives sample requests into the doorway counter: a directed opening over
// width extremes, cooldown after reset, counts at empty occupancy and a
// timeout, then randomised crossings, broken crossings and noise under a run
// of register settings, and finally a back-to-back run of inward crossings.
// Both channels idle at random, and the result side holds off for a long
// stretch so the block backs up.
// ----------------------------------------------------------------------------
module dual_beam_direction_counter_tb;
  import dbdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    fault_count;
  int                    outstanding;
  int                    quiet_cycles = 0;
  int                    hold_left = 0;
  int unsigned           gap_pct = 7;
  int unsigned           stall_pct = 66;
  int unsigned           requests_sent = 0;
  logic [31:0]           now_ms = 32'd0;
  logic [DIST_W-1:0]     enter_now = 14'd1280;
  logic [DIST_W-1:0]     leave_now = 14'd1600;
  int unsigned           timeout_now = 3000;
  int unsigned           cooldown_now = 500;

  dual_beam_direction_counter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dual_beam_direction_counter_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fault_count (fault_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dual_beam_direction_counter: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold off the result side while a long stall is pending
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic offer(input in_t s);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic offer_echo(input logic [15:0] wa, wb, input logic [31:0] t);
    now_ms = t;
    offer({wa, wb, t});
  endtask

  function automatic logic [15:0] beam_width(input bit blocked);
    int unsigned lo_edge;
    int unsigned hi_edge;
    int unsigned span;
    lo_edge = 32'((enter_now < leave_now) ? enter_now : leave_now);
    hi_edge = 32'((enter_now > leave_now) ? enter_now : leave_now);
    if (blocked) begin
      if (lo_edge <= 33) return 16'($urandom_range(65535));
      if (lo_edge > 6401) lo_edge = 6401;
      span = $urandom_range(lo_edge - 1, 32);
    end else begin
      if (hi_edge >= 6400 || $urandom_range(3) == 0)
        return $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 25000));
      span = $urandom_range(6400, hi_edge + 1);
    end
    return 16'((span * 4096 + 1123) / 1124);
  endfunction

  task automatic send_beams(input bit ba, input bit bb);
    in_t s;
    now_ms += $urandom_range(150);
    s.echo_width_a = beam_width(ba);
    s.echo_width_b = beam_width(bb);
    s.time_ms      = now_ms;
    offer(s);
  endtask

  task automatic run_traffic(input int unsigned items);
    int unsigned stop_at;
    int unsigned pick;
    bit          first_a;
    in_t         junk;
    stop_at = requests_sent + items;
    while (requests_sent < stop_at) begin
      pick    = $urandom_range(99);
      first_a = 1'($urandom_range(1));
      if (pick < 70) begin
        repeat ($urandom_range(3, 1)) send_beams(first_a, !first_a);
        repeat ($urandom_range(3, 1)) send_beams(1'b1, 1'b1);
        repeat ($urandom_range(3, 0)) send_beams(!first_a, first_a);
        repeat ($urandom_range(4, 2)) send_beams(1'b0, 1'b0);
        now_ms += $urandom_range(2 * cooldown_now);
      end else if (pick < 85) begin
        repeat ($urandom_range(3, 1)) send_beams(first_a, !first_a);
        if ($urandom_range(1)) now_ms += timeout_now + $urandom_range(2000, 1);
        if ($urandom_range(1)) repeat ($urandom_range(3, 1)) send_beams(1'b1, 1'b1);
        repeat ($urandom_range(3, 1))
          send_beams(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(6, 1)) begin
          junk   = {$urandom, $urandom};
          now_ms = $urandom_range(1) ? junk.time_ms : now_ms + $urandom_range(70000);
          junk.time_ms = now_ms;
          offer(junk);
        end
      end
    end
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input logic [DIST_W-1:0] enter, leave,
                                input logic [15:0] tmo, cool, input bit invert);
    drain_results;
    write_reg(CFG_ENTER, {2'($urandom), enter});
    write_reg(CFG_LEAVE, {2'($urandom), leave});
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_COOLDOWN, cool);
    write_reg(CFG_INVERT, {15'($urandom), invert});
    write_reg(CFG_IDX_W'($urandom_range(7, 5)), 16'($urandom));
    enter_now    = enter;
    leave_now    = leave;
    timeout_now  = 32'(tmo);
    cooldown_now = 32'(cool);
  endtask

  initial begin
    in_t         step;
    int unsigned rnd_enter;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // width extremes and edges of the distance window, all inside the cooldown
    offer_echo(16'd0, 16'd65535, 32'd0);
    offer_echo(16'd65535, 16'd0, 32'd1);
    offer_echo(16'd24999, 16'd25000, 32'd2);
    offer_echo(16'd116, 16'd117, 32'd3);
    offer_echo(16'd23323, 16'd23326, 32'd4);
    offer_echo(16'd0, 16'd1000, 32'd5);
    offer_echo(16'd0, 16'd1000, 32'd6);
    // outward crossing at empty occupancy
    offer_echo(16'd0, 16'd1000, 32'd600);
    offer_echo(16'd1000, 16'd1000, 32'd700);
    offer_echo(16'd1000, 16'd1000, 32'd800);
    offer_echo(16'd1000, 16'd0, 32'd900);
    offer_echo(16'd1000, 16'd0, 32'd1000);
    offer_echo(16'd0, 16'd0, 32'd1100);
    offer_echo(16'd0, 16'd0, 32'd1200);
    // inward crossing, counted straight from both beams blocked
    offer_echo(16'd1000, 16'd0, 32'd1800);
    offer_echo(16'd1000, 16'd0, 32'd1900);
    offer_echo(16'd1000, 16'd1000, 32'd2000);
    offer_echo(16'd1000, 16'd1000, 32'd2100);
    offer_echo(16'd0, 16'd0, 32'd2200);
    offer_echo(16'd0, 16'd0, 32'd2300);
    // open crossing left to time out, then the timestamp wraps
    offer_echo(16'd1000, 16'd0, 32'd3000);
    offer_echo(16'd1000, 16'd0, 32'd3100);
    offer_echo(16'd1000, 16'd0, 32'd6200);
    offer_echo(16'd1000, 16'd0, 32'd6300);
    offer_echo(16'd0, 16'd0, 32'hFFFF_FFFF);
    offer_echo(16'd0, 16'd0, 32'd1);

    for (int p = 0; p < 7; p++) begin
      if (p == 2) begin
        gap_pct   = 66;
        stall_pct = 7;
      end
      if (p == 4) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      case (p)
        0: apply_settings(14'd1280, 14'd1600, 16'd3000, 16'd500, 1'b0);
        1: apply_settings(14'h3FFF, 14'd0, 16'd0, 16'd0, 1'b1);
        2: apply_settings(14'd0, 14'h3FFF, 16'hFFFF, 16'hFFFF, 1'b0);
        default: begin
          rnd_enter = $urandom_range(3000, 200);
          apply_settings(14'(rnd_enter), 14'(rnd_enter + $urandom_range(1000) - 200),
                         16'($urandom_range(5000, 300)), 16'($urandom_range(1500)),
                         1'($urandom_range(1)));
        end
      endcase
      if (p == 1 || p == 4) hold_left = 80;
      run_traffic(225);
    end

    // back-to-back six-sample inward crossings
    apply_settings(14'd2000, 14'd2000, 16'hFFFF, 16'd0, 1'b0);
    gap_pct   = 0;
    stall_pct = 0;
    repeat (20) begin
      for (int k = 0; k < 6; k++) begin
        now_ms++;
        step.echo_width_a = (k < 4) ? 16'd1000 : 16'd10000;
        step.echo_width_b = (k == 2 || k == 3) ? 16'd1000 : 16'd10000;
        step.time_ms      = now_ms;
        offer(step);
      end
    end

    drain_results;
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("dual_beam_direction_counter: match");
    end else begin
      $display("dual_beam_direction_counter: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dbdc_pkg.sv
rtl/dbdc_front.sv
rtl/dbdc_queue.sv
rtl/dbdc_back.sv
rtl/dual_beam_direction_counter.sv
tb/dual_beam_direction_counter_checker.sv
tb/dual_beam_direction_counter_tb.sv
